// ----- rtl/core/bri_pkg.sv -----
package bri_pkg;

  localparam int WORD_BITS   = 64;
  localparam int WORD_COUNT  = 1024;
  localparam int WORD_AW     = 10;
  localparam int BIT_SEL_W   = 6;
  localparam int POS_W       = 16;
  localparam int DIR_DEPTH   = 1024;
  localparam int DIR_AW      = 10;
  localparam int DIR_CNT_W   = DIR_AW + 1;
  localparam int RANK_W      = 16;
  localparam int CNT_W       = POS_W + 1;
  localparam int POP_W       = BIT_SEL_W + 1;
  localparam int SHIFT_W     = 5;
  localparam int CAP_W       = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_WORD = 2'd0,
    OP_LOAD_DIR  = 2'd1,
    OP_QUERY     = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_SEARCH,
    ST_PROBE,
    ST_COUNT_RD,
    ST_COUNT_ACC,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [BIT_SEL_W-1:0] lo;
    logic [BIT_SEL_W-1:0] hi;
  } bit_range_t;

endpackage

// ----- rtl/core/bri_ram.sv -----
module bri_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/bri_popcnt.sv -----
module bri_popcnt
  import bri_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  input  bit_range_t           range,
  output logic [POP_W-1:0]     count
);

  localparam int BYTES = WORD_BITS / 8;

  logic [WORD_BITS-1:0] masked;
  logic [3:0]           byte_cnt [BYTES];

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      masked[i] = word[i] && (BIT_SEL_W'(i) >= range.lo) && (BIT_SEL_W'(i) <= range.hi);
    end
  end

  always_comb begin
    for (int b = 0; b < BYTES; b++) begin
      byte_cnt[b] = '0;
      for (int j = 0; j < 8; j++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(masked[b*8 + j]);
      end
    end
  end

  always_comb begin
    count = '0;
    for (int b = 0; b < BYTES; b++) begin
      count = count + POP_W'(byte_cnt[b]);
    end
  end

endmodule

// ----- rtl/core/bitset_rank_index_lookup.sv -----
// Rank lookup over a stored bit vector with a sampled start directory.
// Input channel (in_valid/in_ready) carries load and query items. A word load
// writes one 64-bit vector word, a directory load writes one start position;
// each is taken while the block is idle and gives no result. A query names a bit
// position and gives one result on the output channel (out_valid/out_ready):
// found, and the rank index of that bit when found.
// One query is worked on at a time. When the position is out of range or its
// bit is clear, the query goes straight to its result; otherwise a binary
// search over the directory entries finds the interval start, and a count
// walk then covers the vector words from that start to the position. Each
// binary search step and each word of the count walk is one read of a
// registered memory followed by a state that uses its data.
// A finished result sits in the output register; if the receiver stalls, the
// block takes loads while idle; a next result waits until the register frees.
// Synchronous reset clears the control state and the configuration registers;
// the vector and directory memories keep their contents and must be loaded
// before they are queried.
module bitset_rank_index_lookup
  import bri_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_op,
  input  logic [WORD_AW-1:0]     in_slot,
  input  logic [WORD_BITS-1:0]   in_load_data,
  input  logic [POS_W-1:0]       in_query_bit,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_found,
  output logic [RANK_W-1:0]      out_rank_index
);

  state_t                state_r, state_nxt;
  logic [SHIFT_W-1:0]    shift_amount_r;
  logic [CAP_W-1:0]      bit_capacity_r;
  logic [DIR_CNT_W-1:0]  table_entries_r;

  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [DIR_CNT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [DIR_CNT_W-1:0]  interval_r, interval_nxt;
  logic [POS_W-1:0]      start_r, start_nxt;
  logic [WORD_AW-1:0]    word_r, word_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  found_r, found_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [RANK_W-1:0]     out_rank_r, out_rank_nxt;

  logic                  word_we, word_re, dir_we, dir_re;
  logic [WORD_AW-1:0]    word_raddr;
  logic [DIR_AW-1:0]     dir_raddr;
  logic [WORD_BITS-1:0]  word_rdata;
  logic [POS_W-1:0]      dir_rdata;

  bit_range_t            pc_range;
  logic [POP_W-1:0]      pc_count;

  logic                  in_accept;
  logic [DIR_CNT_W-1:0]  entries_lim;
  logic [DIR_CNT_W:0]    mid_sum;
  logic [RANK_W-1:0]     rank_val;

  bri_ram #(.WIDTH(WORD_BITS), .DEPTH(WORD_COUNT)) u_word_ram (
    .clk     (clk),
    .wr_en   (word_we),
    .wr_addr (in_slot),
    .wr_data (in_load_data),
    .rd_en   (word_re),
    .rd_addr (word_raddr),
    .rd_data (word_rdata)
  );

  bri_ram #(.WIDTH(POS_W), .DEPTH(DIR_DEPTH)) u_dir_ram (
    .clk     (clk),
    .wr_en   (dir_we),
    .wr_addr (in_slot),
    .wr_data (in_load_data[POS_W-1:0]),
    .rd_en   (dir_re),
    .rd_addr (dir_raddr),
    .rd_data (dir_rdata)
  );

  bri_popcnt u_popcnt (
    .word  (word_rdata),
    .range (pc_range),
    .count (pc_count)
  );

  assign in_ready       = (state_r == ST_IDLE);
  assign in_accept      = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_rank_index = out_rank_r;

  assign entries_lim = (table_entries_r > DIR_CNT_W'(DIR_DEPTH)) ?
                       DIR_CNT_W'(DIR_DEPTH) : table_entries_r;
  assign mid_sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign rank_val    = (RANK_W'(interval_r) << shift_amount_r)
                       + cnt_r[RANK_W-1:0] - RANK_W'(1);

  always_comb begin
    pc_range.lo = (word_r == start_r[POS_W-1:BIT_SEL_W]) ?
                  start_r[BIT_SEL_W-1:0] : '0;
    pc_range.hi = (word_r == pos_r[POS_W-1:BIT_SEL_W]) ?
                  pos_r[BIT_SEL_W-1:0] : '1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_amount_r  <= '0;
      bit_capacity_r  <= '0;
      table_entries_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHIFT:    shift_amount_r  <= cfg_wdata[SHIFT_W-1:0];
        CFG_CAPACITY: bit_capacity_r  <= cfg_wdata[CAP_W-1:0];
        CFG_ENTRIES:  table_entries_r <= cfg_wdata[DIR_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    interval_r  <= interval_nxt;
    start_r     <= start_nxt;
    word_r      <= word_nxt;
    cnt_r       <= cnt_nxt;
    found_r     <= found_nxt;
    out_found_r <= out_found_nxt;
    out_rank_r  <= out_rank_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    interval_nxt  = interval_r;
    start_nxt     = start_r;
    word_nxt      = word_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_rank_nxt  = out_rank_r;
    word_we       = 1'b0;
    dir_we        = 1'b0;
    word_re       = 1'b0;
    dir_re        = 1'b0;
    word_raddr    = word_r;
    dir_raddr     = mid_r[DIR_AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_LOAD_WORD: word_we = 1'b1;
            OP_LOAD_DIR:  dir_we  = 1'b1;
            OP_QUERY: begin
              pos_nxt = in_query_bit;
              if ({1'b0, in_query_bit} >= bit_capacity_r) begin
                found_nxt = 1'b0;
                state_nxt = ST_RESULT;
              end else begin
                word_re    = 1'b1;
                word_raddr = in_query_bit[POS_W-1:BIT_SEL_W];
                state_nxt  = ST_BIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_BIT: begin
        if (!word_rdata[pos_r[BIT_SEL_W-1:0]]) begin
          found_nxt = 1'b0;
          state_nxt = ST_RESULT;
        end else begin
          lo_nxt       = '0;
          hi_nxt       = entries_lim;
          interval_nxt = '0;
          start_nxt    = '0;
          state_nxt    = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[DIR_CNT_W:1];
          dir_re    = 1'b1;
          dir_raddr = mid_sum[DIR_AW:1];
          state_nxt = ST_PROBE;
        end else begin
          word_nxt  = start_r[POS_W-1:BIT_SEL_W];
          cnt_nxt   = '0;
          state_nxt = ST_COUNT_RD;
        end
      end

      ST_PROBE: begin
        if (dir_rdata <= pos_r) begin
          interval_nxt = mid_r + DIR_CNT_W'(1);
          start_nxt    = dir_rdata;
          lo_nxt       = mid_r + DIR_CNT_W'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = ST_SEARCH;
      end

      ST_COUNT_RD: begin
        word_re   = 1'b1;
        state_nxt = ST_COUNT_ACC;
      end

      ST_COUNT_ACC: begin
        cnt_nxt = cnt_r + CNT_W'(pc_count);
        if (word_r == pos_r[POS_W-1:BIT_SEL_W]) begin
          found_nxt = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          word_nxt  = word_r + WORD_AW'(1);
          state_nxt = ST_COUNT_RD;
        end
      end

      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_rank_nxt  = found_r ? rank_val : '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (lo_r <= hi_r))
    else $error("search bounds crossed");

  a_start_not_past_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COUNT_RD) |-> (start_r <= pos_r))
    else $error("interval start beyond queried position");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COUNT_RD) |-> (word_r <= pos_r[POS_W-1:BIT_SEL_W]))
    else $error("count walk ran past the queried word");

  a_miss_zero_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_rank_index == '0))
    else $error("not-found result carries a nonzero rank");
`endif

endmodule
